FILE: design/sha256_pkg.sv
package sha256_pkg;

   typedef logic [31:0] word_type;

   // eight words, index 0 is H0 / a
   typedef logic [7:0][31:0] hash_type;

   typedef struct packed {
      logic load;   // core: copy chaining value; schedule: shift in a message word
      logic step;   // run one round / expand one schedule word
   } sha256_ctrl_type;

   // listed H7 down to H0 so that INIT_VALUE[0] is H0
   localparam hash_type INIT_VALUE = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type round_const(input logic [5:0] idx);
      case (idx)
         6'd0:  round_const = 32'h428a2f98;
         6'd1:  round_const = 32'h71374491;
         6'd2:  round_const = 32'hb5c0fbcf;
         6'd3:  round_const = 32'he9b5dba5;
         6'd4:  round_const = 32'h3956c25b;
         6'd5:  round_const = 32'h59f111f1;
         6'd6:  round_const = 32'h923f82a4;
         6'd7:  round_const = 32'hab1c5ed5;
         6'd8:  round_const = 32'hd807aa98;
         6'd9:  round_const = 32'h12835b01;
         6'd10: round_const = 32'h243185be;
         6'd11: round_const = 32'h550c7dc3;
         6'd12: round_const = 32'h72be5d74;
         6'd13: round_const = 32'h80deb1fe;
         6'd14: round_const = 32'h9bdc06a7;
         6'd15: round_const = 32'hc19bf174;
         6'd16: round_const = 32'he49b69c1;
         6'd17: round_const = 32'hefbe4786;
         6'd18: round_const = 32'h0fc19dc6;
         6'd19: round_const = 32'h240ca1cc;
         6'd20: round_const = 32'h2de92c6f;
         6'd21: round_const = 32'h4a7484aa;
         6'd22: round_const = 32'h5cb0a9dc;
         6'd23: round_const = 32'h76f988da;
         6'd24: round_const = 32'h983e5152;
         6'd25: round_const = 32'ha831c66d;
         6'd26: round_const = 32'hb00327c8;
         6'd27: round_const = 32'hbf597fc7;
         6'd28: round_const = 32'hc6e00bf3;
         6'd29: round_const = 32'hd5a79147;
         6'd30: round_const = 32'h06ca6351;
         6'd31: round_const = 32'h14292967;
         6'd32: round_const = 32'h27b70a85;
         6'd33: round_const = 32'h2e1b2138;
         6'd34: round_const = 32'h4d2c6dfc;
         6'd35: round_const = 32'h53380d13;
         6'd36: round_const = 32'h650a7354;
         6'd37: round_const = 32'h766a0abb;
         6'd38: round_const = 32'h81c2c92e;
         6'd39: round_const = 32'h92722c85;
         6'd40: round_const = 32'ha2bfe8a1;
         6'd41: round_const = 32'ha81a664b;
         6'd42: round_const = 32'hc24b8b70;
         6'd43: round_const = 32'hc76c51a3;
         6'd44: round_const = 32'hd192e819;
         6'd45: round_const = 32'hd6990624;
         6'd46: round_const = 32'hf40e3585;
         6'd47: round_const = 32'h106aa070;
         6'd48: round_const = 32'h19a4c116;
         6'd49: round_const = 32'h1e376c08;
         6'd50: round_const = 32'h2748774c;
         6'd51: round_const = 32'h34b0bcb5;
         6'd52: round_const = 32'h391c0cb3;
         6'd53: round_const = 32'h4ed8aa4a;
         6'd54: round_const = 32'h5b9cca4f;
         6'd55: round_const = 32'h682e6ff3;
         6'd56: round_const = 32'h748f82ee;
         6'd57: round_const = 32'h78a5636f;
         6'd58: round_const = 32'h84c87814;
         6'd59: round_const = 32'h8cc70208;
         6'd60: round_const = 32'h90befffa;
         6'd61: round_const = 32'ha4506ceb;
         6'd62: round_const = 32'hbef9a3f7;
         6'd63: round_const = 32'hc67178f2;
         default: round_const = 32'h0;
      endcase
   endfunction

endpackage

FILE: design/sha256_schedule.sv
module sha256_schedule
   import sha256_pkg::*;
(
   input  logic            clock,
   input  sha256_ctrl_type ctrl,
   input  word_type        msg_word,
   output word_type        round_word
);

   // win_ff[0] is W[t] of the current round, win_ff[15] the newest word
   word_type win_ff [16];
   word_type win_in [16];
   word_type next_word;

   assign next_word = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign round_word = win_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctrl.load || ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = ctrl.load ? msg_word : next_word;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

FILE: design/sha256_round_core.sv
module sha256_round_core
   import sha256_pkg::*;
(
   input  logic            clock,
   input  sha256_ctrl_type ctrl,
   input  hash_type        chain_value,
   input  word_type        round_word,
   input  logic [5:0]      round_index,
   output hash_type        work_vars
);

   hash_type vars_ff;
   hash_type vars_in;
   word_type ch;
   word_type maj;
   word_type t1;
   word_type t2;

   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + round_const(round_index) + round_word;
   assign t2  = big_sigma0(vars_ff[0]) + maj;

   always_comb begin
      vars_in = vars_ff;
      if (ctrl.load) begin
         vars_in = chain_value;
      end else if (ctrl.step) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   assign work_vars = vars_ff;

endmodule

FILE: design/sha256_block_compressor.sv
// SHA-256 compressor for an already padded message. The host sends 32-bit big-endian words,
// sixteen to a 512-bit block; tuser[0] on the first word of a message reloads the initial hash
// value and restarts the block, tuser[1] on any word of the last block asks for the digest.
// Words are taken one per cycle until the sixteenth; then req_tready drops for 64 rounds on
// one shared round unit (one round a cycle, schedule words expanded from a sixteen-word shift
// window alongside) and an add step that adds the result into the chaining value. The eight
// digest words, H0 first, leave from a buffer with tuser holding the word number and tlast on
// the eighth; the next message loads while they drain, and a final block whose digest finds
// the buffer still full waits in the add step until it empties.
module sha256_block_compressor
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] msg_word
   input  logic [1:0]  req_tuser,   // [0] start_message, [1] final_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_number
   output logic        rsp_tlast
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [3:0]      word_count_ff, word_count_in;
   logic [5:0]      round_ff, round_in;
   logic            final_ff, final_in;
   logic            out_busy_ff, out_busy_in;
   logic [2:0]      out_idx_ff, out_idx_in;
   hash_type        chain_ff, chain_in;
   hash_type        digest_ff, digest_in;
   hash_type        sums;
   hash_type        work_vars;
   word_type        round_word;
   sha256_ctrl_type core_ctrl;
   sha256_ctrl_type sched_ctrl;
   logic            req_accept;
   logic            rsp_accept;
   logic [3:0]      word_idx;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign word_idx   = req_tuser[0] ? 4'd0 : word_count_ff;

   sha256_schedule u_schedule (
      .clock      (clock),
      .ctrl       (sched_ctrl),
      .msg_word   (req_tdata),
      .round_word (round_word)
   );

   sha256_round_core u_round_core (
      .clock       (clock),
      .ctrl        (core_ctrl),
      .chain_value (chain_ff),
      .round_word  (round_word),
      .round_index (round_ff),
      .work_vars   (work_vars)
   );

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sums[i] = chain_ff[i] + work_vars[i];
      end
   end

   always_comb begin
      state_in        = state_ff;
      word_count_in   = word_count_ff;
      round_in        = round_ff;
      final_in        = final_ff;
      out_busy_in     = out_busy_ff;
      out_idx_in      = out_idx_ff;
      chain_in        = chain_ff;
      digest_in       = digest_ff;
      core_ctrl       = '0;
      sched_ctrl      = '0;
      sched_ctrl.load = req_accept;

      // drain the digest buffer
      if (rsp_accept) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == 3'd7) begin
            out_busy_in = 1'b0;
         end
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (req_tuser[0]) begin
                  chain_in = INIT_VALUE;
               end
               final_in = (final_ff && !req_tuser[0]) || req_tuser[1];
               if (word_idx == 4'd15) begin
                  word_count_in  = 4'd0;
                  core_ctrl.load = 1'b1;
                  state_in       = ST_ROUND;
               end else begin
                  word_count_in = word_idx + 4'd1;
               end
            end
         end
         ST_ROUND: begin
            core_ctrl.step  = 1'b1;
            sched_ctrl.step = 1'b1;
            round_in        = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the previous digest is gone if this block emits one
            if (!final_ff || !out_busy_ff) begin
               chain_in = sums;
               state_in = ST_LOAD;
               if (final_ff) begin
                  digest_in   = sums;
                  out_busy_in = 1'b1;
                  out_idx_in  = 3'd0;
                  final_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         word_count_ff <= 4'd0;
         round_ff      <= 6'd0;
         final_ff      <= 1'b0;
         out_busy_ff   <= 1'b0;
         out_idx_ff    <= 3'd0;
         chain_ff      <= INIT_VALUE;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         round_ff      <= round_in;
         final_ff      <= final_in;
         out_busy_ff   <= out_busy_in;
         out_idx_ff    <= out_idx_in;
         chain_ff      <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      digest_ff <= digest_in;
   end

   assign rsp_tvalid = out_busy_ff;
   assign rsp_tdata  = digest_ff[out_idx_ff];
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == 3'd7);

`ifndef SYNTHESIS
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (round_ff == 6'd0))
      else $error("round counter moved outside the round phase");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'd63) |=> (state_ff == ST_DONE))
      else $error("round phase did not end after 64 rounds");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_tlast) |=> !rsp_tvalid)
      else $error("digest buffer still valid after its last word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && final_ff && out_busy_ff) |=> (state_ff == ST_DONE))
      else $error("digest buffer reloaded while still draining");
`endif

endmodule
